>>> design/dq_pkg.sv
// Shared types and constants for the bounded deque unit.
// Holds the request codes and the request/response beat layouts.
// No dependencies.
package dq_pkg;

    // Fixed field widths of the stream beats
    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int DOUT_W  = 32;
    localparam int CNT_W   = 9;

    // Packed stream widths (padded to whole bytes)
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Request codes; codes 6 and 7 are unused and fail
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT  = 3'd0,
        FN_APPEND_BACK = 3'd1,
        FN_POP_FRONT   = 3'd2,
        FN_REMOVE_BACK = 3'd3,
        FN_REMOVE_IDX  = 3'd4,
        FN_READ_IDX    = 3'd5
    } func_t;

    typedef struct packed {
        func_t                     func;
        logic signed [VALUE_W-1:0] value;
        logic        [POS_W-1:0]   position;
    } req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DOUT_W-1:0] data_out;
        logic        [CNT_W-1:0]  count;
    } rsp_t;

endpackage

>>> design/dq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used as the ring store of the deque. No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/dq_ctrl.sv
// Request sequencer of the deque: ring pointers, count and RAM access control.
// Depends on dq_pkg; drives one dq_ram instance held by the top level.
module dq_ctrl #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request side
    input  logic                  req_valid,
    output logic                  req_ready,
    input  dq_pkg::req_t          req,
    // response side
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output dq_pkg::rsp_t          rsp,
    // RAM port
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [DATA_WIDTH-1:0] ram_wdata,
    output logic [AW-1:0]         ram_raddr,
    input  logic [DATA_WIDTH-1:0] ram_rdata
);

    import dq_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SHIFT,
        ST_RESP
    } state_t;

    state_t                     state_reg, state_next;
    func_t                      func_reg, func_next;
    logic [VALUE_W-1:0]         value_reg, value_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [AW-1:0]              front_reg, front_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              rd_off_reg, rd_off_next;
    logic [AW-1:0]              rd_slot_reg, rd_slot_next;
    logic                       ok_reg, ok_next;
    logic [DOUT_W-1:0]          data_reg, data_next;

    logic [AW-1:0]              calc_off;
    logic [AW-1:0]              slot_addr;
    logic [AW-1:0]              front_dec;
    logic                       not_full;
    logic                       pos_ok;
    logic [CW-1:0]              pos_w;
    logic [CW-1:0]              pos_inc;
    logic [CW-1:0]              rd_off_inc;

    // Ring position of an offset from the front
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, front} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Shared address arithmetic
    assign slot_addr  = slot_of(front_reg, calc_off);
    assign front_dec  = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign not_full   = (count_reg < CW'(DEPTH));
    assign pos_ok     = (CMPW'(pos_reg) < CMPW'(count_reg));
    assign pos_w      = CW'(pos_reg);
    assign pos_inc    = pos_w + CW'(1);
    assign rd_off_inc = rd_off_reg + CW'(1);

    assign req_ready     = (state_reg == ST_IDLE);
    assign rsp_valid     = (state_reg == ST_RESP);
    assign rsp.ok        = ok_reg;
    assign rsp.data_out  = data_reg;
    assign rsp.count     = CNT_W'(count_reg);
    assign ram_raddr     = slot_addr;

    // Next-state and RAM control
    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        value_next   = value_reg;
        pos_next     = pos_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        rd_off_next  = rd_off_reg;
        rd_slot_next = rd_slot_reg;
        ok_next      = ok_reg;
        data_next    = data_reg;
        calc_off     = '0;
        ram_we       = 1'b0;
        ram_waddr    = rd_slot_reg;
        ram_wdata    = ram_rdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    func_next  = req.func;
                    value_next = req.value;
                    pos_next   = req.position;
                    state_next = ST_EXEC;
                end
            end

            // Inserts finish here; removals and reads issue their first read
            ST_EXEC: begin
                ok_next    = 1'b0;
                data_next  = '0;
                state_next = ST_RESP;
                unique case (func_reg)
                    FN_PUSH_FRONT: begin
                        if (not_full) begin
                            ram_we     = 1'b1;
                            ram_waddr  = front_dec;
                            ram_wdata  = DATA_WIDTH'(value_reg);
                            front_next = front_dec;
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    FN_APPEND_BACK: begin
                        calc_off = AW'(count_reg);
                        if (not_full) begin
                            ram_we     = 1'b1;
                            ram_waddr  = slot_addr;
                            ram_wdata  = DATA_WIDTH'(value_reg);
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    FN_POP_FRONT: begin
                        calc_off = '0;
                        if (count_reg != '0) begin
                            state_next = ST_READ;
                        end
                    end
                    FN_REMOVE_BACK: begin
                        calc_off = AW'(count_reg - CW'(1));
                        if (count_reg != '0) begin
                            state_next = ST_READ;
                        end
                    end
                    FN_REMOVE_IDX, FN_READ_IDX: begin
                        calc_off = AW'(pos_w);
                        if (pos_ok) begin
                            state_next = ST_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Read data is back: capture it, then update or start the shift
            ST_READ: begin
                data_next  = DOUT_W'(ram_rdata);
                ok_next    = 1'b1;
                state_next = ST_RESP;
                unique case (func_reg)
                    FN_POP_FRONT: begin
                        calc_off   = AW'(1);
                        front_next = slot_addr;
                        count_next = count_reg - CW'(1);
                    end
                    FN_REMOVE_BACK: begin
                        count_next = count_reg - CW'(1);
                    end
                    FN_REMOVE_IDX: begin
                        calc_off = AW'(pos_inc);
                        if (pos_inc < count_reg) begin
                            rd_off_next  = pos_inc;
                            rd_slot_next = slot_addr;
                            state_next   = ST_SHIFT;
                        end else begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // One entry per cycle: write the word read last cycle one slot
            // toward the front, read the next one
            ST_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = (rd_slot_reg == '0) ? AW'(DEPTH - 1) : rd_slot_reg - AW'(1);
                ram_wdata = ram_rdata;
                calc_off  = AW'(rd_off_inc);
                if (rd_off_inc < count_reg) begin
                    rd_off_next  = rd_off_inc;
                    rd_slot_next = slot_addr;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_RESP;
                end
            end

            ST_RESP: begin
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
        func_reg    <= func_next;
        value_reg   <= value_next;
        pos_reg     <= pos_next;
        rd_off_reg  <= rd_off_next;
        rd_slot_reg <= rd_slot_next;
        ok_reg      <= ok_next;
        data_reg    <= data_next;
    end

endmodule

>>> design/bounded_deque_with_indexed_access_unit.sv
// Bounded double-ended queue of words in a ring store, with indexed access.
// Top level: stream ports, output register, sequencer and ring RAM.
// Depends on dq_pkg, dq_ctrl and dq_ram.
//
// Usage:
//   Each input beat (s_ side) carries one request: push front, append back,
//   pop front, remove back, remove at index, or read at index (s_tuser).
//   Every request yields exactly one result beat (m_ side) with a success
//   flag, the word removed or read (zero on failure or insert) and the new
//   entry count. Full, empty and out-of-range requests fail and change nothing.
// Timing:
//   Requests are taken one at a time. Inserts and failures finish in the
//   execute state; pop, remove back and read at index add a read state; remove
//   at index adds a read state and, unless the last entry goes, a shift state
//   that moves one entry per cycle through the single read and write port of
//   the ring RAM. The response state then waits until the output register takes
//   the result, and the sequencer returns to idle before the next request is taken.
// Reset:
//   aresetn (synchronous, active low) empties the deque; store contents are
//   not cleared and need no clearing pass.
// Backpressure:
//   The output register holds a result while m_tready is low; the next
//   request is still taken and runs until its own result is due.
module bounded_deque_with_indexed_access_unit #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dq_pkg::S_TDATA_W-1:0]   s_tdata,  // value[31:0], position[39:32]
    input  logic [dq_pkg::FUNC_W-1:0]      s_tuser,  // func[2:0]
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dq_pkg::M_TDATA_W-1:0]   m_tdata,  // data_out[31:0], count[40:32], zero pad
    output logic                           m_tuser   // ok
);

    import dq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    req_t                  req;
    rsp_t                  rsp;
    logic                  rsp_valid;
    logic                  rsp_ready;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  m_valid_reg, m_valid_next;
    rsp_t                  m_rsp_reg, m_rsp_next;

    // Unpack request beat
    assign req.func     = func_t'(s_tuser);
    assign req.value    = s_tdata[VALUE_W-1:0];
    assign req.position = s_tdata[VALUE_W +: POS_W];

    dq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: loads when empty or draining this cycle
    assign rsp_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        if (rsp_ready) begin
            m_valid_next = rsp_valid;
            if (rsp_valid) begin
                m_rsp_next = rsp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_rsp_reg <= m_rsp_next;
    end

    // Pack result beat
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_rsp_reg.ok;
    assign m_tdata  = {(M_TDATA_W - DOUT_W - CNT_W)'(0), m_rsp_reg.count,
                       m_rsp_reg.data_out};

endmodule

>>> dv/tb_top.sv
// Testbench for the bounded deque unit: random and directed requests over the stream ports.
// A local deque predictor works out each result when its request beat is accepted.
// Depends on dq_pkg and bounded_deque_with_indexed_access_unit.
`timescale 1ns / 100ps

module tb_top;
    import dq_pkg::*;

    localparam int DEPTH       = 256;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 300;

    // func codes 6 and 7 have no operation behind them
    localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd7;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // value[31:0], position[39:32]
    logic [FUNC_W-1:0]    s_tuser;   // func[2:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // data_out[31:0], count[40:32], zero pad
    logic                 m_tuser;   // ok

    // idle rates in percent, and a counter that asks the receiver for a long hold
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_seq;
    int err_count;

    // predictor state: ring of words, front slot and entry count
    logic [31:0] ring_words [DEPTH];
    logic [7:0]  ring_head;
    logic [8:0]  ring_fill;

    rsp_t pending_results [$];

    bounded_deque_with_indexed_access_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] ring_slot(int offset);
        return 8'(int'(ring_head) + offset);
    endfunction

    // Apply one request to the predicted deque and return the result it yields
    function automatic rsp_t deque_apply(logic [FUNC_W-1:0] code, logic [31:0] word,
                                         logic [7:0] pos);
        rsp_t r;
        int   i;
        r = '0;
        case (code)
            FN_PUSH_FRONT: if (ring_fill < DEPTH) begin
                ring_head = ring_head - 8'd1;
                ring_words[ring_head] = word;
                ring_fill++;
                r.ok = 1'b1;
            end
            FN_APPEND_BACK: if (ring_fill < DEPTH) begin
                ring_words[ring_slot(ring_fill)] = word;
                ring_fill++;
                r.ok = 1'b1;
            end
            FN_POP_FRONT: if (ring_fill != 0) begin
                r.data_out = ring_words[ring_head];
                ring_head  = ring_head + 8'd1;
                ring_fill--;
                r.ok = 1'b1;
            end
            FN_REMOVE_BACK: if (ring_fill != 0) begin
                r.data_out = ring_words[ring_slot(ring_fill - 1)];
                ring_fill--;
                r.ok = 1'b1;
            end
            FN_REMOVE_IDX: if (pos < ring_fill) begin
                r.data_out = ring_words[ring_slot(pos)];
                // close the gap toward the front
                for (i = pos; i + 1 < ring_fill; i++)
                    ring_words[ring_slot(i)] = ring_words[ring_slot(i + 1)];
                ring_fill--;
                r.ok = 1'b1;
            end
            FN_READ_IDX: if (pos < ring_fill) begin
                r.data_out = ring_words[ring_slot(pos)];
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = ring_fill;
        return r;
    endfunction

    // Offer one request beat; called and returns at a falling edge
    task automatic send_req(logic [FUNC_W-1:0] code, logic [31:0] word, logic [7:0] pos);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, word};
        s_tuser  <= code;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(deque_apply(code, word, pos));
        @(negedge aclk);
    endtask

    // Drop valid and wait until every result is back
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    // One random request; inserts are favored while the deque is below target
    task automatic send_random(int target);
        logic [FUNC_W-1:0] code;
        logic [31:0]       word;
        logic [7:0]        pos;
        int                r;
        int                ins_pct;
        ins_pct = (ring_fill < target) ? 60 : 25;
        r = $urandom_range(0, 99);
        if (r < 3)
            code = $urandom_range(0, 1) ? FN_UNUSED_B : FN_UNUSED_A;
        else if (r < 3 + ins_pct)
            code = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_APPEND_BACK;
        else begin
            r = $urandom_range(0, 99);
            if (r < 25)      code = FN_POP_FRONT;
            else if (r < 45) code = FN_REMOVE_BACK;
            else if (r < 70) code = FN_REMOVE_IDX;
            else             code = FN_READ_IDX;
        end
        word = $urandom;
        // mostly valid indexes, sometimes anything
        if (ring_fill != 0 && $urandom_range(0, 99) < 85)
            pos = 8'($urandom_range(0, ring_fill - 1));
        else
            pos = 8'($urandom);
        send_req(code, word, pos);
    endtask

    // Empty-store failures, unused codes, word extremes and every operation
    task automatic test_basic_ops();
        send_req(FN_POP_FRONT,   32'h0, 8'd0);
        send_req(FN_REMOVE_BACK, 32'h0, 8'd0);
        send_req(FN_READ_IDX,    32'h0, 8'd0);
        send_req(FN_REMOVE_IDX,  32'h0, 8'd0);
        send_req(FN_UNUSED_A,    32'hFFFF_FFFF, 8'd255);
        send_req(FN_UNUSED_B,    32'hFFFF_FFFF, 8'd255);
        send_req(FN_PUSH_FRONT,  32'h7FFF_FFFF, 8'd0);
        send_req(FN_PUSH_FRONT,  32'h8000_0000, 8'd0);
        send_req(FN_APPEND_BACK, 32'h0000_0000, 8'd255);
        send_req(FN_APPEND_BACK, 32'hFFFF_FFFF, 8'd0);
        send_req(FN_READ_IDX,    32'h0, 8'd0);
        send_req(FN_READ_IDX,    32'h0, 8'd3);
        send_req(FN_READ_IDX,    32'h0, 8'd4);
        send_req(FN_READ_IDX,    32'h0, 8'd255);
        send_req(FN_REMOVE_IDX,  32'h0, 8'd1);
        send_req(FN_REMOVE_IDX,  32'h0, 8'd5);
        send_req(FN_POP_FRONT,   32'h0, 8'd0);
        send_req(FN_REMOVE_BACK, 32'h0, 8'd0);
        send_req(FN_REMOVE_IDX,  32'h0, 8'd0);
        send_req(FN_POP_FRONT,   32'h0, 8'd0);
        send_req(FN_APPEND_BACK, 32'h5A5A_5A5A, 8'd0);
        send_req(FN_PUSH_FRONT,  32'hA5A5_A5A5, 8'd0);
        send_req(FN_REMOVE_IDX,  32'h0, 8'd1);
        send_req(FN_REMOVE_BACK, 32'h0, 8'd0);
        finish_phase();
    endtask

    task automatic test_random_mix(int n_items, int target);
        repeat (n_items) send_random(target);
        finish_phase();
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure_fill();
        hold_seq++;
        repeat (40) send_random(32);
        finish_phase();
    endtask

    // Fill to capacity, hit the full-store failures and the longest shifts, then drain to 24 entries
    task automatic test_full_store();
        while (ring_fill < DEPTH)
            send_req($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_APPEND_BACK, $urandom,
                     8'($urandom));
        send_req(FN_PUSH_FRONT,  $urandom, 8'd0);
        send_req(FN_APPEND_BACK, $urandom, 8'd0);
        send_req(FN_READ_IDX,    32'h0, 8'd255);
        send_req(FN_READ_IDX,    32'h0, 8'd0);
        send_req(FN_REMOVE_IDX,  32'h0, 8'd255);
        send_req(FN_APPEND_BACK, $urandom, 8'd0);
        send_req(FN_REMOVE_IDX,  32'h0, 8'd0);
        send_req(FN_PUSH_FRONT,  $urandom, 8'd0);
        send_req(FN_READ_IDX,    32'h0, 8'd128);
        send_req(FN_POP_FRONT,   32'h0, 8'd0);
        send_req(FN_REMOVE_BACK, 32'h0, 8'd0);
        while (ring_fill > 24) begin
            case ($urandom_range(0, 9))
                0:          send_req(FN_REMOVE_IDX, 32'h0, 8'($urandom_range(0, ring_fill - 1)));
                1, 2, 3, 4: send_req(FN_POP_FRONT, 32'h0, 8'($urandom));
                default:    send_req(FN_REMOVE_BACK, 32'h0, 8'($urandom));
            endcase
        end
        finish_phase();
    endtask

    // Receiver ready: random idling, plus a long hold when one is requested
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Result check against the oldest outstanding prediction
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.ok) begin
                    $error("ok mismatch: expected %0d, got %0d", want.ok, m_tuser);
                    err_count++;
                end
                if (m_tdata[31:0] !== want.data_out) begin
                    $error("data_out mismatch: expected %0d, got %0d",
                           want.data_out, $signed(m_tdata[31:0]));
                    err_count++;
                end
                if (m_tdata[40:32] !== want.count) begin
                    $error("count mismatch: expected %0d, got %0d", want.count, m_tdata[40:32]);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_seq    = 0;
        err_count   = 0;
        ring_head   = '0;
        ring_fill   = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sender idles lightly, receiver heavily
        tx_idle_pct = 18;
        rx_idle_pct = 65;
        test_basic_ops();
        test_random_mix(100, 16);

        // the other way round
        tx_idle_pct = 65;
        rx_idle_pct = 18;
        test_random_mix(100, 64);
        test_backpressure_fill();

        // no idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_full_store();
        test_random_mix(40, 200);

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
